FILE: rtl/core/tsb_pkg.sv
// Shared types, codes and blend tables for the two-layer sprite blitter.
package tsb_pkg;

  localparam int CFG_W       = 9;    // frame_width / frame_height register width
  localparam int CFG_IDX_W   = 1;
  localparam int COORD_W     = 16;
  localparam int IN_TDATA_W  = 168;  // 167 bits of fields, padded to whole bytes
  localparam int OUT_TDATA_W = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // Foreground bits of a nibble
  localparam logic [3:0] FG_MASK = 4'hc;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_BLIT1 = 2'd2,
    FUNC_BLIT2 = 2'd3
  } tsb_func_t;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_PIX   = 7'b0000100,
    S_AG1   = 7'b0001000,
    S_AG2   = 7'b0010000,
    S_WR    = 7'b0100000,
    S_DONE  = 7'b1000000
  } tsb_state_t;

  // Location status from the address unit
  typedef struct packed {
    logic hit;  // pixel inside the frame and the store
    logic odd;  // odd x: low nibble
  } tsb_loc_t;

  // Blend colour per sprite pixel value (row) and mode (column)
  localparam logic [1:0] BLEND_TAB [4][16] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1,
      2'd2, 2'd2, 2'd0, 2'd2, 2'd3, 2'd3, 2'd3, 2'd0},
    '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
      2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1,
      2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1},
    '{2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2,
      2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2}
  };

  // Bit m set: mode m also draws pixel value 0 (clear in modes 5, 10, 15)
  localparam logic [15:0] DRAW_ZERO_MASK = 16'h7bdf;

  function automatic logic [1:0] blend_col(input logic [1:0] ch, input logic [3:0] mode);
    return BLEND_TAB[ch][mode];
  endfunction

  function automatic logic draws_zero(input logic [3:0] mode);
    return DRAW_ZERO_MASK[mode];
  endfunction

endpackage

FILE: rtl/core/tsb_frame_mem.sv
// Frame store: one write port, one read port with registered read data.
module tsb_frame_mem #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rd_data_r
);

  logic [7:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[raddr];
  end

endmodule

FILE: rtl/core/tsb_addr_unit.sv
// Two-stage pixel address unit: bounds check and row multiply, then add and depth check.
module tsb_addr_unit #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic                          clk,
  input  logic [tsb_pkg::COORD_W-1:0]   px,
  input  logic [tsb_pkg::COORD_W-1:0]   py,
  input  logic [tsb_pkg::CFG_W-1:0]     wid,
  input  logic [tsb_pkg::CFG_W-1:0]     hgt,
  output tsb_pkg::tsb_loc_t             loc_r,
  output logic [AW-1:0]                 addr_r
);
  import tsb_pkg::*;

  localparam int PROD_W = 2 * CFG_W;
  localparam int SUM_W  = PROD_W + 1;

  // stage 1
  logic              inb_r;
  logic [PROD_W-1:0] prod_r;
  logic [CFG_W-1:0]  xl_r;
  logic              inb_nxt;
  logic [PROD_W-1:0] prod_nxt;

  // stage 2
  logic [SUM_W-1:0]  sum;
  tsb_loc_t          loc_nxt;

  always_comb begin
    inb_nxt  = (px < COORD_W'(wid)) && (py < COORD_W'(hgt));
    prod_nxt = PROD_W'(py[CFG_W-1:0]) * PROD_W'(wid);
  end

  always_ff @(posedge clk) begin
    inb_r  <= inb_nxt;
    prod_r <= prod_nxt;
    xl_r   <= px[CFG_W-1:0];
  end

  always_comb begin
    sum         = SUM_W'(prod_r) + SUM_W'(xl_r);
    loc_nxt.hit = inb_r && (sum[SUM_W-1:1] < DEPTH);
    loc_nxt.odd = xl_r[0];
  end

  always_ff @(posedge clk) begin
    loc_r  <= loc_nxt;
    addr_r <= AW'(sum[SUM_W-1:1]);
  end

endmodule

FILE: rtl/core/two_layer_sprite_blitter.sv
// Top level: two-layer 2bpp frame store with pixel read/write and 8x8 sprite blits.
// Each pixel passes S_PIX, then S_AG1 and S_AG2 (two-stage address unit), then S_WR
//   for the read-modify-write; a transparent pixel stops after S_PIX, an off-frame one after S_AG2.
// Throughput: one item at a time; the next is taken the cycle after the result is registered.
// Reset: synchronous, active low; a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT/2 bytes (32768 at
//   the defaults) of the store, in_tready stays low meanwhile; config writes still taken.
module two_layer_sprite_blitter #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [tsb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsb_pkg::CFG_W-1:0]         cfg_wdata,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // layer[0], pos_x[16:1], pos_y[32:17], color[36:33], flip_x[37], flip_y[38],
  // plane_low[102:39], plane_high[166:103], zero pad [167]
  input  logic [tsb_pkg::IN_TDATA_W-1:0]    in_tdata,
  // func[1:0]
  input  logic [1:0]                        in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // read_color[1:0], changed[2], zero pad [7:3]
  output logic [tsb_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import tsb_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT / 2;
  localparam int AW    = $clog2(DEPTH);
  // register values saturate at the frame limits; storing the saturated value is equivalent
  localparam int W_LIM = (MAX_WIDTH  > 511) ? 511 : MAX_WIDTH;
  localparam int H_LIM = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
  localparam int W_RST = (MAX_WIDTH  < 256) ? MAX_WIDTH  : 256;
  localparam int H_RST = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

  // ---------------------------------------------------------------- state
  tsb_state_t             state_r, state_nxt;
  logic [AW-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic [5:0]             cnt_r, cnt_nxt;      // sprite pixel: {row, column}
  logic                   chg_r, chg_nxt;
  logic [1:0]             rc_r, rc_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [1:0]             out_rc_r;
  logic                   out_chg_r;
  logic [CFG_W-1:0]       wid_r, hgt_r;

  // item held for the whole transaction
  tsb_func_t              func_r;
  logic                   layer_r;
  logic [COORD_W-1:0]     x_r, y_r;
  logic [3:0]             color_r;
  logic                   fx_r, fy_r;
  logic [63:0]            lo_r, hi_r;

  logic                   in_acc;
  logic                   out_load;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wid_r <= CFG_W'(W_RST);
      hgt_r <= CFG_W'(H_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  wid_r <= (cfg_wdata > MAX_WIDTH)  ? CFG_W'(W_LIM) : cfg_wdata;
        CFG_FRAME_HEIGHT: hgt_r <= (cfg_wdata > MAX_HEIGHT) ? CFG_W'(H_LIM) : cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input capture
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r  <= tsb_func_t'(in_tuser);
      layer_r <= in_tdata[0];
      x_r     <= in_tdata[16:1];
      y_r     <= in_tdata[32:17];
      color_r <= in_tdata[36:33];
      fx_r    <= in_tdata[37];
      fy_r    <= in_tdata[38];
      lo_r    <= in_tdata[102:39];
      hi_r    <= in_tdata[166:103];
    end
  end

  // ---------------------------------------------------------------- current pixel
  // Everything below depends only on cnt_r and the held item, so it stays
  // stable while one pixel walks through the address unit.
  logic                   is_blit;
  logic [2:0]             hh, vv, off_x, off_y;
  logic [5:0]             bit_idx;
  logic [1:0]             pix_ch, pix_col;
  logic                   pix_skip, last_pix;
  logic [COORD_W-1:0]     px, py;

  always_comb begin
    is_blit  = (func_r == FUNC_BLIT1) || (func_r == FUNC_BLIT2);
    hh       = cnt_r[2:0];
    vv       = cnt_r[5:3];
    bit_idx  = {vv, ~hh};                       // bit 7 of a row is its leftmost pixel
    pix_ch   = {(func_r == FUNC_BLIT2) && hi_r[bit_idx], lo_r[bit_idx]};
    off_x    = is_blit ? (fx_r ? ~hh : hh) : 3'd0;
    off_y    = is_blit ? (fy_r ? ~vv : vv) : 3'd0;
    px       = x_r + COORD_W'(off_x);          // wraps modulo 2^16
    py       = y_r + COORD_W'(off_y);
    pix_skip = is_blit && (pix_ch == 2'd0) && !draws_zero(color_r);
    pix_col  = is_blit ? blend_col(pix_ch, color_r) : color_r[1:0];
    last_pix = !is_blit || (&cnt_r);
  end

  // ---------------------------------------------------------------- address unit and store
  tsb_loc_t               loc;
  logic [AW-1:0]          loc_addr;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [7:0]             mem_wdata;
  logic [7:0]             rd_data;

  tsb_addr_unit #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_addr (
    .clk    (clk),
    .px     (px),
    .py     (py),
    .wid    (wid_r),
    .hgt    (hgt_r),
    .loc_r  (loc),
    .addr_r (loc_addr)
  );

  tsb_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .we        (mem_we),
    .waddr     (mem_waddr),
    .wdata     (mem_wdata),
    .raddr     (loc_addr),
    .rd_data_r (rd_data)
  );

  // ---------------------------------------------------------------- read-modify-write
  logic [1:0]             fld;
  logic [2:0]             sh;
  logic [7:0]             new_byte;
  logic [3:0]             nib;
  logic [1:0]             vis_col;

  always_comb begin
    fld      = {~loc.odd, layer_r};           // even x in the high nibble, fg above bg
    sh       = {fld, 1'b0};
    new_byte = (rd_data & ~(8'h03 << sh)) | ({6'd0, pix_col} << sh);
    nib      = loc.odd ? rd_data[3:0] : rd_data[7:4];
    vis_col  = ((nib & FG_MASK) != 4'd0) ? nib[3:2] : nib[1:0];
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    cnt_nxt     = cnt_r;
    chg_nxt     = chg_r;
    rc_nxt      = rc_r;
    mem_we      = 1'b0;
    mem_waddr   = loc_addr;
    mem_wdata   = new_byte;
    out_load    = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = 8'h00;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cnt_nxt   = 6'd0;
          chg_nxt   = 1'b0;
          rc_nxt    = 2'd0;
          state_nxt = S_PIX;
        end
      end
      S_PIX: begin
        // px/py enter the address unit this cycle
        if (pix_skip) begin
          if (last_pix) begin
            state_nxt = S_DONE;
          end else begin
            cnt_nxt = cnt_r + 6'd1;
          end
        end else begin
          state_nxt = S_AG1;
        end
      end
      S_AG1: begin
        state_nxt = S_AG2;
      end
      S_AG2: begin
        // store read is issued at loc_addr this cycle
        if (loc.hit) begin
          state_nxt = S_WR;
        end else if (last_pix) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + 6'd1;
          state_nxt = S_PIX;
        end
      end
      S_WR: begin
        if (func_r == FUNC_READ) begin
          rc_nxt = vis_col;
        end else if (new_byte != rd_data) begin
          mem_we  = 1'b1;
          chg_nxt = 1'b1;
        end
        if (last_pix) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + 6'd1;
          state_nxt = S_PIX;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_comb begin
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rc_r  <= rc_r;
      out_chg_r <= chg_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 3){1'b0}}, out_chg_r, out_rc_r};

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      cnt_r        <= 6'd0;
      chg_r        <= 1'b0;
      rc_r         <= 2'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      cnt_r        <= cnt_nxt;
      chg_r        <= chg_nxt;
      rc_r         <= rc_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // ---------------------------------------------------------------- assertions
  // a write-back in S_WR only follows a read issued in the previous cycle
  a_wr_after_ag2: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WR |-> $past(state_r) == S_AG2)
    else $error("write-back without preceding address cycle");

  // a read never marks the store as changed
  a_read_no_chg: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(chg_r) |-> func_r != FUNC_READ)
    else $error("changed set by a read");

  // only a read returns a colour
  a_rc_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && func_r != FUNC_READ) |-> rc_r == 2'd0)
    else $error("colour returned by a non-read");

  // a finished result waits while the output register is still held
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_tvalid_r && !out_tready) |=> state_r == S_DONE)
    else $error("result dropped while output stalled");

endmodule
